>>> src/assert_macros.svh
// Assertion helpers for the RTL; lmfps_back is the file that includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define LMFPS_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lmfps: same-cycle check failed");

// Next-cycle implication.
`define LMFPS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lmfps: next-cycle check failed");

`endif

>>> src/lmfps_pkg.sv
package lmfps_pkg;

   localparam logic [1:0] OP_SET_ONE = 2'd0;
   localparam logic [1:0] OP_SET_ALL = 2'd1;
   localparam logic [1:0] OP_FADE    = 2'd2;
   localparam logic [1:0] OP_SCAN    = 2'd3;

   localparam logic [1:0] ST_RED    = 2'd0;
   localparam logic [1:0] ST_GREEN  = 2'd1;
   localparam logic [1:0] ST_OFF    = 2'd2;
   localparam logic [1:0] ST_YELLOW = 2'd3;

   localparam logic [2:0] CSR_LEVEL_RED          = 3'd0;
   localparam logic [2:0] CSR_LEVEL_GREEN        = 3'd1;
   localparam logic [2:0] CSR_LEVEL_YELLOW_RED   = 3'd2;
   localparam logic [2:0] CSR_LEVEL_YELLOW_GREEN = 3'd3;
   localparam logic [2:0] CSR_WAIT_STEP          = 3'd4;

   localparam logic [6:0] ON_R  = 7'd84;
   localparam logic [6:0] ON_G  = 7'd64;
   localparam logic [6:0] ON_YR = 7'd84;
   localparam logic [6:0] ON_YG = 7'd30;
   localparam logic [5:0] WAIT_RESET = 6'd10;

   localparam logic signed [8:0] CUR_FLOOR = -9'sd255;

   localparam logic [7:0] SLOT_LEVEL [32] = '{
      8'd192, 8'd40,  8'd224, 8'd8,   8'd24,  8'd152, 8'd128, 8'd104,
      8'd184, 8'd16,  8'd88,  8'd216, 8'd208, 8'd240, 8'd176, 8'd232,
      8'd200, 8'd32,  8'd160, 8'd72,  8'd248, 8'd80,  8'd56,  8'd112,
      8'd136, 8'd0,   8'd48,  8'd144, 8'd168, 8'd64,  8'd96,  8'd120
   };

   typedef struct packed {
      logic [6:0] level_red;
      logic [6:0] level_green;
      logic [6:0] level_yellow_red;
      logic [6:0] level_yellow_green;
      logic [5:0] wait_step;
   } cfg_type;

   typedef struct packed {
      logic [1:0] op;
      logic [3:0] led_index;
      logic [1:0] led_state;
      logic       all_red;
      logic       all_green;
      logic [2:0] column;
      logic       col_ok;
      logic [7:0] level;
   } cmd_type;

   // Add with saturation at the current floor.
   function automatic logic signed [8:0] add_floor(logic signed [8:0] a,
                                                   logic signed [8:0] b);
      logic signed [9:0] s;
      s = $signed({a[8], a}) + $signed({b[8], b});
      if (s < $signed({CUR_FLOOR[8], CUR_FLOOR})) begin
         return CUR_FLOOR;
      end
      return s[8:0];
   endfunction

endpackage

>>> src/lmfps_front.sv
module lmfps_front #(
   parameter int NUM_COLUMNS = 6,
   parameter int PWM_SLOTS   = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [15:0]         req_tdata,
   input  logic [1:0]          req_tuser,
   output logic                push_valid,
   input  logic                push_ready,
   output lmfps_pkg::cmd_type  push_cmd
);

   lmfps_pkg::cmd_type cmd_ff;
   lmfps_pkg::cmd_type cmd_in;
   logic               valid_ff;
   logic [5:0]         slot;

   always_comb begin
      // fold the slot into the PWM period: at most three subtractions
      slot = {1'b0, req_tdata[12:8]};
      for (int k = 0; k < 3; k++) begin
         if (int'(slot) >= PWM_SLOTS) begin
            slot = slot - 6'(PWM_SLOTS);
         end
      end
      cmd_in.op        = req_tuser;
      cmd_in.led_index = req_tdata[3:0];
      cmd_in.led_state = req_tdata[5:4];
      cmd_in.all_red   = req_tdata[6];
      cmd_in.all_green = req_tdata[7];
      cmd_in.column    = req_tdata[15:13];
      cmd_in.col_ok    = int'(req_tdata[15:13]) < NUM_COLUMNS;
      cmd_in.level     = lmfps_pkg::SLOT_LEVEL[slot[4:0]];
   end

   assign req_tready = !valid_ff || push_ready;
   assign push_valid = valid_ff;
   assign push_cmd   = cmd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            valid_ff <= 1'b1;
            cmd_ff   <= cmd_in;
         end else if (push_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

endmodule

>>> src/lmfps_queue.sv
module lmfps_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  lmfps_pkg::cmd_type  push_cmd,
   output logic                pop_valid,
   input  logic                pop_ready,
   output lmfps_pkg::cmd_type  pop_cmd
);

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);

   lmfps_pkg::cmd_type     entry_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff;
   logic [PTR_W-1:0]       rd_ptr_ff;
   logic [PTR_W:0]         count_ff;
   logic                   push;
   logic                   pop;

   assign push_ready = int'(count_ff) < DEPTH;
   assign pop_valid  = count_ff != '0;
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            entry_ff[wr_ptr_ff] <= push_cmd;
            wr_ptr_ff           <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

>>> src/lmfps_back.sv
`include "assert_macros.svh"

module lmfps_back #(
   parameter int NUM_CHANNELS  = 30,
   parameter int NUM_ROWS      = 5,
   parameter int STAGGER_COUNT = 14
) (
   input  logic                clock,
   input  logic                reset,
   input  lmfps_pkg::cfg_type  cfg,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  lmfps_pkg::cmd_type  pop_cmd,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata
);

   localparam int HALF     = NUM_CHANNELS / 2;
   localparam int CH_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int ROW_W    = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
   localparam int SCAN_W   = 3 + ROW_W;
   localparam int STEP_MAX = (NUM_CHANNELS > 8) ? NUM_CHANNELS : 8;
   localparam int STEP_W   = $clog2(STEP_MAX);
   localparam int EXT_W    = NUM_ROWS + 5;
   localparam logic signed [8:0] STAG_INIT =
      9'(-(STAGGER_COUNT * int'(lmfps_pkg::WAIT_RESET)));

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_RUN  = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0]              state_ff;
   lmfps_pkg::cmd_type      cmd_ff;
   logic [STEP_W-1:0]       step_ff;
   logic [6:0]              target_ff  [NUM_CHANNELS];
   logic signed [8:0]       current_ff [NUM_CHANNELS];
   logic signed [8:0]       stagger_ff;
   logic signed [8:0]       minus_ff;
   logic                    tz_ff;
   logic [NUM_ROWS-1:0]     drive_ff;
   logic                    moved_ff;
   logic                    rsp_valid_ff;
   logic [4:0]              rsp_row_ff;
   logic                    rsp_on_ff;
   logic                    rsp_fade_ff;

   logic [CH_W-1:0]         red_addr;
   logic [CH_W-1:0]         green_addr;
   logic                    idx_ok;
   logic [SCAN_W-1:0]       scan_ch;
   logic                    ch_ok;
   logic [CH_W-1:0]         addr;
   logic [6:0]              rd_t;
   logic signed [8:0]       rd_c;
   logic signed [8:0]       tgt_s;
   logic                    we_t;
   logic                    we_c;
   logic [6:0]              wd_t;
   logic signed [8:0]       wd_c;
   logic                    last;
   logic                    hit;
   logic                    moved_now;
   logic                    both_zero;
   logic signed [8:0]       minus;
   logic [6:0]              set_r;
   logic [6:0]              set_g;
   logic [6:0]              all_r;
   logic [6:0]              all_g;
   logic                    out_free;
   logic [EXT_W-1:0]        drive_ext;

   always_comb begin
      red_addr   = CH_W'(cmd_ff.led_index);
      green_addr = red_addr + CH_W'(HALF);
      idx_ok     = int'(cmd_ff.led_index) < HALF;
      scan_ch    = SCAN_W'(cmd_ff.column) * SCAN_W'(NUM_ROWS)
                 + SCAN_W'(step_ff[ROW_W-1:0]);
      ch_ok      = int'(scan_ch) < NUM_CHANNELS;

      case (cmd_ff.op)
         lmfps_pkg::OP_SET_ONE: addr = (step_ff == STEP_W'(1)) ? green_addr : red_addr;
         lmfps_pkg::OP_SCAN:    addr = CH_W'(scan_ch);
         default:               addr = step_ff[CH_W-1:0];
      endcase
      rd_t  = target_ff[addr];
      rd_c  = current_ff[addr];
      tgt_s = $signed({2'b00, rd_t});

      case (cmd_ff.led_state)
         lmfps_pkg::ST_RED: begin
            set_r = cfg.level_red;
            set_g = '0;
         end
         lmfps_pkg::ST_GREEN: begin
            set_r = '0;
            set_g = cfg.level_green;
         end
         lmfps_pkg::ST_YELLOW: begin
            set_r = cfg.level_yellow_red;
            set_g = cfg.level_yellow_green;
         end
         default: begin
            set_r = '0;
            set_g = '0;
         end
      endcase
      all_r = cmd_ff.all_red ?
              (cmd_ff.all_green ? cfg.level_yellow_red : cfg.level_red) : '0;
      all_g = cmd_ff.all_green ?
              (cmd_ff.all_red ? cfg.level_yellow_green : cfg.level_green) : '0;

      both_zero = tz_ff && (rd_t == '0) && (stagger_ff < 0);
      minus     = both_zero ? stagger_ff : '0;
      hit       = ch_ok && cmd_ff.col_ok
                && ($signed({rd_c[8], rd_c}) > $signed({2'b00, cmd_ff.level}));
      moved_now = tgt_s != rd_c;

      we_t = 1'b0;
      we_c = 1'b0;
      wd_t = rd_t;
      wd_c = rd_c;
      last = 1'b0;
      if (state_ff == S_RUN) begin
         case (cmd_ff.op)
            lmfps_pkg::OP_SET_ONE: begin
               // step 0 reads red, step 1 writes green, step 2 writes red
               if (!idx_ok) begin
                  last = 1'b1;
               end else if (step_ff == STEP_W'(1)) begin
                  we_t = 1'b1;
                  we_c = 1'b1;
                  wd_t = set_g;
                  wd_c = lmfps_pkg::add_floor(rd_c, minus);
               end else if (step_ff == STEP_W'(2)) begin
                  we_t = 1'b1;
                  we_c = 1'b1;
                  wd_t = set_r;
                  wd_c = lmfps_pkg::add_floor(rd_c, minus_ff);
                  last = 1'b1;
               end
            end
            lmfps_pkg::OP_SET_ALL: begin
               we_t = 1'b1;
               wd_t = (int'(step_ff) < HALF) ? all_r : all_g;
               last = int'(step_ff) == NUM_CHANNELS - 1;
            end
            lmfps_pkg::OP_FADE: begin
               we_c = moved_now;
               wd_c = (tgt_s > rd_c) ? rd_c + 9'sd1 : rd_c - 9'sd1;
               last = int'(step_ff) == NUM_CHANNELS - 1;
            end
            default: begin
               last = int'(step_ff) == NUM_ROWS - 1;
            end
         endcase
      end
   end

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign pop_ready  = state_ff == S_IDLE;
   assign drive_ext  = EXT_W'(drive_ff);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_fade_ff, rsp_on_ff, rsp_row_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         stagger_ff   <= STAG_INIT;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            target_ff[i]  <= '0;
            current_ff[i] <= '0;
         end
      end else begin
         if (we_t) begin
            target_ff[addr] <= wd_t;
         end
         if (we_c) begin
            current_ff[addr] <= wd_c;
         end
         if (state_ff == S_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (pop_valid) begin
                  cmd_ff   <= pop_cmd;
                  step_ff  <= '0;
                  drive_ff <= '0;
                  moved_ff <= 1'b0;
                  state_ff <= S_RUN;
               end
            end
            S_RUN: begin
               step_ff <= step_ff + 1'b1;
               if (cmd_ff.op == lmfps_pkg::OP_SET_ONE) begin
                  if (step_ff == '0) begin
                     tz_ff <= rd_t == '0;
                  end else if (step_ff == STEP_W'(1)) begin
                     minus_ff <= minus;
                     if (both_zero) begin
                        stagger_ff <= stagger_ff + $signed({3'b000, cfg.wait_step});
                     end
                  end
               end
               if (cmd_ff.op == lmfps_pkg::OP_FADE && moved_now) begin
                  moved_ff <= 1'b1;
               end
               if (cmd_ff.op == lmfps_pkg::OP_SCAN) begin
                  drive_ff[step_ff[ROW_W-1:0]] <= hit;
               end
               if (last) begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (out_free) begin
                  rsp_row_ff  <= drive_ext[4:0];
                  rsp_on_ff   <= |drive_ff;
                  rsp_fade_ff <= moved_ff;
                  state_ff    <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   `LMFPS_ASSERT_IMPLY(a_stagger_bound, clock, reset, 1'b1, stagger_ff < 9'sd63)
   `LMFPS_ASSERT_IMPLY(a_current_floor, clock, reset, we_c, wd_c >= lmfps_pkg::CUR_FLOOR)
   `LMFPS_ASSERT_IMPLY(a_drive_scan_only, clock, reset,
                       state_ff == S_DONE && cmd_ff.op != lmfps_pkg::OP_SCAN, drive_ff == '0)
   `LMFPS_ASSERT_IMPLY(a_moved_fade_only, clock, reset,
                       state_ff == S_DONE && cmd_ff.op != lmfps_pkg::OP_FADE, !moved_ff)
   `LMFPS_ASSERT_NEXT(a_result_issued, clock, reset,
                      state_ff == S_DONE && out_free, rsp_valid_ff && state_ff == S_IDLE)

endmodule

>>> src/led_matrix_fade_pwm_scanner.sv
// Channel  Direction  Contents
// req      in         tdata: led_index, led_state, all_red, all_green, pwm_slot, column
//                     tuser: req_type
// rsp      out        tdata: row_drive, column_on, fading
// csr      in         csr_index selects a level or wait_step register, csr_data
//
// A set request reads red, then writes green and red; an LED beyond the matrix is only read.
// Scan, set-all and fade walk the back end's store one entry a cycle.
// A two-entry queue and the front register take new requests while the back end works.
// A held rsp beat stalls the back end; once the queue and front register fill, req_tready
// drops. csr writes are always ready.
// Synchronous reset clears all brightness state; no clearing pass follows.
module led_matrix_fade_pwm_scanner #(
   parameter int NUM_CHANNELS  = 30,
   parameter int NUM_ROWS      = 5,
   parameter int NUM_COLUMNS   = 6,
   parameter int PWM_SLOTS     = 32,
   parameter int STAGGER_COUNT = 14
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [3:0] led_index, [5:4] led_state, [6] all_red, [7] all_green,
   // [12:8] pwm_slot, [15:13] column
   input  logic [15:0] req_tdata,
   // [1:0] req_type
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [4:0] row_drive, [5] column_on, [6] fading, [7] zero
   output logic [7:0]  rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [6:0]  csr_data
);

   lmfps_pkg::cfg_type cfg_ff;
   lmfps_pkg::cmd_type push_cmd;
   lmfps_pkg::cmd_type pop_cmd;
   logic               push_valid;
   logic               push_ready;
   logic               pop_valid;
   logic               pop_ready;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.level_red          <= lmfps_pkg::ON_R;
         cfg_ff.level_green        <= lmfps_pkg::ON_G;
         cfg_ff.level_yellow_red   <= lmfps_pkg::ON_YR;
         cfg_ff.level_yellow_green <= lmfps_pkg::ON_YG;
         cfg_ff.wait_step          <= lmfps_pkg::WAIT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            lmfps_pkg::CSR_LEVEL_RED:          cfg_ff.level_red          <= csr_data;
            lmfps_pkg::CSR_LEVEL_GREEN:        cfg_ff.level_green        <= csr_data;
            lmfps_pkg::CSR_LEVEL_YELLOW_RED:   cfg_ff.level_yellow_red   <= csr_data;
            lmfps_pkg::CSR_LEVEL_YELLOW_GREEN: cfg_ff.level_yellow_green <= csr_data;
            lmfps_pkg::CSR_WAIT_STEP:          cfg_ff.wait_step          <= csr_data[5:0];
            default: begin
               // drop writes to unknown registers
            end
         endcase
      end
   end

   lmfps_front #(
      .NUM_COLUMNS (NUM_COLUMNS),
      .PWM_SLOTS   (PWM_SLOTS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   lmfps_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   lmfps_back #(
      .NUM_CHANNELS  (NUM_CHANNELS),
      .NUM_ROWS      (NUM_ROWS),
      .STAGGER_COUNT (STAGGER_COUNT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

>>> bench/led_matrix_checker.sv
`timescale 1ns / 100ps

module led_matrix_checker #(
   parameter int NUM_CHANNELS  = 30,
   parameter int NUM_ROWS      = 5,
   parameter int NUM_COLUMNS   = 6,
   parameter int PWM_SLOTS     = 32,
   parameter int STAGGER_COUNT = 14
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   // [3:0] led_index, [5:4] led_state, [6] all_red, [7] all_green,
   // [12:8] pwm_slot, [15:13] column
   input  logic [15:0] req_tdata,
   // [1:0] req_type
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [4:0] row_drive, [5] column_on, [6] fading, [7] zero
   input  logic [7:0]  rsp_tdata,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [6:0]  csr_data,
   output int          mismatches,
   output int          outstanding
);

   localparam int HALF        = NUM_CHANNELS / 2;
   localparam int LEVEL_FLOOR = -255;

   typedef struct packed {
      logic [4:0] rows;
      logic       lit;
      logic       moved;
   } matrix_out_type;

   logic [6:0]        lvl_red;
   logic [6:0]        lvl_green;
   logic [6:0]        lvl_yel_red;
   logic [6:0]        lvl_yel_green;
   logic [5:0]        stagger_step;
   logic [6:0]        goal [NUM_CHANNELS];
   logic signed [8:0] glow [NUM_CHANNELS];
   logic signed [8:0] stagger;
   matrix_out_type    awaited_q [$];
   int                fault_total = 0;

   assign mismatches = fault_total;

   function automatic logic signed [8:0] sink_level(int base, int delta);
      int sum;
      sum = base + delta;
      if (sum < LEVEL_FLOOR) begin
         sum = LEVEL_FLOOR;
      end
      return sum[8:0];
   endfunction

   // Advance the matrix state by one request and return the response it produces.
   function automatic matrix_out_type step_matrix(logic [1:0] op, logic [15:0] data);
      matrix_out_type res;
      logic [3:0]  idx;
      logic [1:0]  shade;
      logic [2:0]  col;
      int          minus;
      int          acc;
      int          want_r;
      int          want_g;
      int          tgt;
      int          cur;
      int          lvl;
      int          ch;
      res = '0;
      case (op)
         lmfps_pkg::OP_SET_ONE: begin
            idx   = data[3:0];
            shade = data[5:4];
            if (idx < HALF) begin
               minus = 0;
               // delay the fade-in of an LED that was dark in both colors
               if (goal[idx] == 0 && goal[idx + HALF] == 0 && stagger < 0) begin
                  minus   = stagger;
                  acc     = stagger;
                  acc     = acc + int'(stagger_step);
                  stagger = acc[8:0];
               end
               case (shade)
                  lmfps_pkg::ST_RED: begin
                     want_r = lvl_red;
                     want_g = 0;
                  end
                  lmfps_pkg::ST_GREEN: begin
                     want_r = 0;
                     want_g = lvl_green;
                  end
                  lmfps_pkg::ST_OFF: begin
                     want_r = 0;
                     want_g = 0;
                  end
                  default: begin
                     want_r = lvl_yel_red;
                     want_g = lvl_yel_green;
                  end
               endcase
               goal[idx]        = 7'(want_r);
               goal[idx + HALF] = 7'(want_g);
               glow[idx]        = sink_level(glow[idx], minus);
               glow[idx + HALF] = sink_level(glow[idx + HALF], minus);
            end
         end
         lmfps_pkg::OP_SET_ALL: begin
            want_r = data[6] ? (data[7] ? lvl_yel_red : lvl_red) : 0;
            want_g = data[7] ? (data[6] ? lvl_yel_green : lvl_green) : 0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
               goal[i] = (i < HALF) ? 7'(want_r) : 7'(want_g);
            end
         end
         lmfps_pkg::OP_FADE: begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
               tgt = goal[i];
               cur = glow[i];
               if (tgt > cur) begin
                  glow[i]   = 9'(cur + 1);
                  res.moved = 1'b1;
               end else if (tgt < cur) begin
                  glow[i]   = 9'(cur - 1);
                  res.moved = 1'b1;
               end
            end
         end
         default: begin
            lvl = lmfps_pkg::SLOT_LEVEL[5'((data[12:8] % PWM_SLOTS) & 31)];
            col = data[15:13];
            if (col < NUM_COLUMNS) begin
               for (int r = 0; r < NUM_ROWS; r++) begin
                  ch = col * NUM_ROWS + r;
                  if (ch < NUM_CHANNELS) begin
                     cur = glow[ch];
                     if (cur > lvl) begin
                        res.rows[r] = 1'b1;
                     end
                  end
               end
            end
            res.lit = |res.rows;
         end
      endcase
      return res;
   endfunction

   function automatic void check_field(string label, int want, int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
         fault_total++;
      end
   endfunction

   always @(posedge clock) begin : watch
      matrix_out_type want;
      if (reset) begin
         lvl_red       = lmfps_pkg::ON_R;
         lvl_green     = lmfps_pkg::ON_G;
         lvl_yel_red   = lmfps_pkg::ON_YR;
         lvl_yel_green = lmfps_pkg::ON_YG;
         stagger_step  = lmfps_pkg::WAIT_RESET;
         stagger       = 9'(-(STAGGER_COUNT * int'(lmfps_pkg::WAIT_RESET)));
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            goal[i] = '0;
            glow[i] = '0;
         end
         awaited_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               lmfps_pkg::CSR_LEVEL_RED:          lvl_red       = csr_data;
               lmfps_pkg::CSR_LEVEL_GREEN:        lvl_green     = csr_data;
               lmfps_pkg::CSR_LEVEL_YELLOW_RED:   lvl_yel_red   = csr_data;
               lmfps_pkg::CSR_LEVEL_YELLOW_GREEN: lvl_yel_green = csr_data;
               lmfps_pkg::CSR_WAIT_STEP:          stagger_step  = csr_data[5:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_q.size() == 0) begin
               $display("%0t: rsp beat mismatch, expected none, actual 0x%02h",
                        $time, rsp_tdata);
               fault_total++;
            end else begin
               want = awaited_q.pop_front();
               check_field("row_drive", want.rows, rsp_tdata[4:0]);
               check_field("column_on", want.lit, rsp_tdata[5]);
               check_field("fading", want.moved, rsp_tdata[6]);
               check_field("pad bit", 0, rsp_tdata[7]);
            end
         end
         if (req_tvalid && req_tready) begin
            awaited_q.push_back(step_matrix(req_tuser, req_tdata));
         end
      end
      outstanding <= awaited_q.size();
   end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps

module testbench;

   localparam int CYCLE_LIMIT   = 600000;
   localparam int SETTLE_CYCLES = 40;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = lmfps_pkg::OP_SET_ONE;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index  = lmfps_pkg::CSR_LEVEL_RED;
   logic [6:0]  csr_data   = '0;

   int          mismatches;
   int          outstanding;
   int          cycle_count = 0;
   int          op_count [4] = '{0, 0, 0, 0};
   logic        calm = 1'b0;

   led_matrix_fade_pwm_scanner i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   led_matrix_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= calm || ($urandom_range(99) >= 35);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, outstanding);
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic logic [15:0] pack_req(logic [3:0] idx, logic [1:0] shade,
                                            logic red, logic green,
                                            logic [4:0] slot, logic [2:0] col);
      return {col, slot, green, red, shade, idx};
   endfunction

   // Keep valid high between back-to-back beats; drop it only for a gap.
   task automatic send_beat(input logic [1:0] op, input logic [15:0] data);
      while (!calm && $urandom_range(99) < 35) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
      op_count[op]++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [6:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic program_levels(input logic [6:0] red, input logic [6:0] green,
                                 input logic [6:0] yel_red, input logic [6:0] yel_green,
                                 input logic [6:0] step);
      write_reg(lmfps_pkg::CSR_LEVEL_RED, red);
      write_reg(lmfps_pkg::CSR_LEVEL_GREEN, green);
      write_reg(lmfps_pkg::CSR_LEVEL_YELLOW_RED, yel_red);
      write_reg(lmfps_pkg::CSR_LEVEL_YELLOW_GREEN, yel_green);
      // unused index, must be ignored
      write_reg(lmfps_pkg::CSR_WAIT_STEP + 3'($urandom_range(1, 3)), 7'($urandom));
      write_reg(lmfps_pkg::CSR_WAIT_STEP, step);
      csr_valid <= 1'b0;
   endtask

   task automatic run_random(input int count, input int fade_pct);
      logic [1:0]  op;
      logic [15:0] data;
      int          pick;
      for (int n = 0; n < count; n++) begin
         data = 16'($urandom);
         pick = $urandom_range(99);
         if (pick < fade_pct) begin
            op = lmfps_pkg::OP_FADE;
         end else if (pick < fade_pct + 30) begin
            op = lmfps_pkg::OP_SET_ONE;
            data[3:0] = ($urandom_range(19) == 0) ? 4'd15 : 4'($urandom_range(14));
         end else if (pick < fade_pct + 40) begin
            op = lmfps_pkg::OP_SET_ALL;
         end else begin
            op = lmfps_pkg::OP_SCAN;
            data[15:13] = ($urandom_range(15) == 0) ? 3'($urandom_range(7, 6))
                                                    : 3'($urandom_range(5));
         end
         send_beat(op, data);
         // hold off now and then until the block has answered everything
         if ($urandom_range(99) == 0) begin
            drain();
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_beat(lmfps_pkg::OP_SCAN, pack_req(0, lmfps_pkg::ST_RED, 0, 0, 25, 0));
      send_beat(lmfps_pkg::OP_SCAN, pack_req(0, lmfps_pkg::ST_RED, 0, 0, 31, 7));
      send_beat(lmfps_pkg::OP_SCAN, pack_req(0, lmfps_pkg::ST_RED, 0, 0, 0, 6));
      send_beat(lmfps_pkg::OP_SET_ONE, pack_req(0, lmfps_pkg::ST_RED, 0, 0, 0, 0));
      send_beat(lmfps_pkg::OP_SET_ONE, pack_req(14, lmfps_pkg::ST_YELLOW, 0, 0, 0, 0));
      send_beat(lmfps_pkg::OP_SET_ONE, pack_req(15, lmfps_pkg::ST_GREEN, 1, 1, 31, 7));
      send_beat(lmfps_pkg::OP_SET_ONE, pack_req(7, lmfps_pkg::ST_OFF, 0, 0, 0, 0));
      send_beat(lmfps_pkg::OP_SET_ONE, pack_req(3, lmfps_pkg::ST_GREEN, 0, 0, 0, 0));
      send_beat(lmfps_pkg::OP_SET_ONE, pack_req(0, lmfps_pkg::ST_YELLOW, 0, 0, 0, 0));
      send_beat(lmfps_pkg::OP_FADE, pack_req(0, lmfps_pkg::ST_RED, 0, 0, 0, 0));
      send_beat(lmfps_pkg::OP_SET_ALL, pack_req(0, lmfps_pkg::ST_RED, 1, 0, 0, 0));
      send_beat(lmfps_pkg::OP_FADE, pack_req(15, lmfps_pkg::ST_YELLOW, 1, 1, 31, 7));
      send_beat(lmfps_pkg::OP_SET_ALL, pack_req(0, lmfps_pkg::ST_RED, 0, 1, 0, 0));
      send_beat(lmfps_pkg::OP_SET_ALL, pack_req(0, lmfps_pkg::ST_RED, 1, 1, 0, 0));
      send_beat(lmfps_pkg::OP_FADE, pack_req(0, lmfps_pkg::ST_RED, 0, 0, 0, 0));
      send_beat(lmfps_pkg::OP_SET_ALL, pack_req(15, lmfps_pkg::ST_YELLOW, 0, 0, 31, 7));
      send_beat(lmfps_pkg::OP_FADE, pack_req(0, lmfps_pkg::ST_RED, 0, 0, 0, 0));
      send_beat(lmfps_pkg::OP_SET_ONE, pack_req(9, lmfps_pkg::ST_RED, 0, 0, 0, 0));
      send_beat(lmfps_pkg::OP_SET_ONE, pack_req(10, lmfps_pkg::ST_YELLOW, 0, 0, 0, 0));
      send_beat(lmfps_pkg::OP_SCAN, pack_req(0, lmfps_pkg::ST_RED, 0, 0, 25, 5));
      send_beat(lmfps_pkg::OP_SCAN, pack_req(0, lmfps_pkg::ST_RED, 0, 0, 16, 3));
      send_beat(lmfps_pkg::OP_FADE, pack_req(0, lmfps_pkg::ST_RED, 0, 0, 0, 0));
      send_beat(lmfps_pkg::OP_SCAN, pack_req(15, lmfps_pkg::ST_YELLOW, 1, 1, 9, 0));
      drain();

      // stagger never advances, so repeated sets drive currents to the floor
      program_levels(127, 127, 127, 127, 0);
      run_random(240, 30);
      drain();
      // wait_step is masked to six bits
      program_levels(0, 0, 0, 0, 7'h41);
      run_random(240, 35);
      drain();
      program_levels(7'($urandom), 7'($urandom), 7'($urandom), 7'($urandom),
                     7'($urandom_range(1, 9)));
      run_random(240, 45);
      drain();
      calm <= 1'b1;
      program_levels(lmfps_pkg::ON_R, lmfps_pkg::ON_G, lmfps_pkg::ON_YR, lmfps_pkg::ON_YG,
                     7'(lmfps_pkg::WAIT_RESET));
      run_random(240, 40);
      drain();
      calm <= 1'b0;
      program_levels(127, 127, 127, 127, 7'h7F);
      run_random(240, 35);
      drain();
      program_levels(7'($urandom), 7'($urandom), 7'($urandom), 7'($urandom),
                     7'($urandom));
      run_random(225, 50);
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d set, %0d set-all, %0d fade and %0d scan requests over six",
               op_count[lmfps_pkg::OP_SET_ONE], op_count[lmfps_pkg::OP_SET_ALL],
               op_count[lmfps_pkg::OP_FADE], op_count[lmfps_pkg::OP_SCAN]);
      $display("level settings, with stagger floor, stray LED, column and CSR index cases.");
      if (mismatches == 0 && outstanding == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+src
src/lmfps_pkg.sv
src/lmfps_front.sv
src/lmfps_queue.sv
src/lmfps_back.sv
src/led_matrix_fade_pwm_scanner.sv
bench/led_matrix_checker.sv
bench/testbench.sv
